/* rtl/sce_pkg.sv */
// ----------------------------------------------------------------------------
// sce_pkg
// Types, constants and exp tables for the softmax cross-entropy loss block.
// ----------------------------------------------------------------------------
package sce_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_LBL,
    ST_LN_NORM,
    ST_LN_SQ,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } sce_state_t;

  localparam logic [16:0] LN2_Q16 = 17'd45426;

  function automatic logic [16:0] exp_whole(input logic [3:0] k);
    logic [16:0] v;
    begin
      unique case (k)
        4'd0:    v = 17'd65536;
        4'd1:    v = 17'd24109;
        4'd2:    v = 17'd8869;
        4'd3:    v = 17'd3263;
        4'd4:    v = 17'd1200;
        4'd5:    v = 17'd442;
        4'd6:    v = 17'd162;
        4'd7:    v = 17'd60;
        4'd8:    v = 17'd22;
        4'd9:    v = 17'd8;
        4'd10:   v = 17'd3;
        4'd11:   v = 17'd1;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic [16:0] exp_sixteenth(input logic [3:0] j);
    logic [16:0] v;
    begin
      unique case (j)
        4'd0:  v = 17'd65536;
        4'd1:  v = 17'd61565;
        4'd2:  v = 17'd57835;
        4'd3:  v = 17'd54331;
        4'd4:  v = 17'd51039;
        4'd5:  v = 17'd47947;
        4'd6:  v = 17'd45042;
        4'd7:  v = 17'd42313;
        4'd8:  v = 17'd39750;
        4'd9:  v = 17'd37341;
        4'd10: v = 17'd35079;
        4'd11: v = 17'd32954;
        4'd12: v = 17'd30957;
        4'd13: v = 17'd29081;
        4'd14: v = 17'd27319;
        default: v = 17'd25664;
      endcase
      return v;
    end
  endfunction

  function automatic logic [16:0] exp_fine(input logic [3:0] i);
    logic [16:0] v;
    begin
      unique case (i)
        4'd0:  v = 17'd65536;
        4'd1:  v = 17'd65280;
        4'd2:  v = 17'd65026;
        4'd3:  v = 17'd64772;
        4'd4:  v = 17'd64520;
        4'd5:  v = 17'd64268;
        4'd6:  v = 17'd64018;
        4'd7:  v = 17'd63768;
        4'd8:  v = 17'd63520;
        4'd9:  v = 17'd63272;
        4'd10: v = 17'd63025;
        4'd11: v = 17'd62780;
        4'd12: v = 17'd62535;
        4'd13: v = 17'd62291;
        4'd14: v = 17'd62048;
        default: v = 17'd61806;
      endcase
      return v;
    end
  endfunction

endpackage

/* rtl/sce_if.sv */
// ----------------------------------------------------------------------------
// sce_if
// Valid/ready channel interfaces for the input, result and config streams.
// ----------------------------------------------------------------------------
interface sce_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] logit;
  logic        [15:0] label;
  logic               last_in_batch;
  modport source (output valid, logit, label, last_in_batch, input ready);
  modport sink   (input valid, logit, label, last_in_batch, output ready);
endinterface

interface sce_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] avg_loss;
  logic        status;
  logic [16:0] row_total;
  modport source (output valid, avg_loss, status, row_total, input ready);
  modport sink   (input valid, avg_loss, status, row_total, output ready);
endinterface

interface sce_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/sce_exp.sv */
// ----------------------------------------------------------------------------
// sce_exp
// Two-stage table exp(-d): whole*sixteenth, register, then *fine.
// ----------------------------------------------------------------------------
module sce_exp
  import sce_pkg::*;
(
  input  logic        clk,
  input  logic [15:0] d,
  output logic [16:0] e
);
  logic [33:0] p1;
  logic [16:0] v1_r;
  logic [3:0]  fi_r;
  logic [33:0] p2;

  assign p1 = ({17'd0, exp_whole((d[15:8] >= 8'd12) ? 4'd12 : d[11:8])}
               * {17'd0, exp_sixteenth(d[7:4])}) + 34'd32768;

  always_ff @(posedge clk) begin
    v1_r <= p1[32:16];
    fi_r <= d[3:0];
  end

  assign p2 = ({17'd0, v1_r} * {17'd0, exp_fine(fi_r)}) + 34'd32768;
  assign e  = p2[32:16];
endmodule

/* rtl/sce_store.sv */
// ----------------------------------------------------------------------------
// sce_store
// Row logit memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module sce_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic        clk,
  input  logic        we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0] rdata
);
  logic [15:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/softmax_cross_entropy_loss.sv */
// ----------------------------------------------------------------------------
// softmax_cross_entropy_loss
// Streams logits row by row; mean softmax cross-entropy loss per batch.
// ----------------------------------------------------------------------------
// Logits are taken one per cycle and written to the row memory. When a row of
// n logits is complete the input stalls while a sequencer reads the row back
// through the one memory read port (one logit a cycle, then the memory read
// register and the exp register drain), reads the labelled logit, takes log2 by
// 16 squaring steps and accumulates. A row with an out-of-range label is
// dropped at once. The batch result adds a 48-step restoring division of the
// accumulator by the row count before the result is offered.
module softmax_cross_entropy_loss
  import sce_pkg::*;
#(
  parameter int MAX_CLASSES = 1024,
  parameter int MAX_ROWS    = 65536
) (
  input logic clk,
  input logic rst_n,
  sce_in_if.sink    in_ch,
  sce_out_if.source out_ch,
  sce_cfg_if.sink   cfg_ch
);
  localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CW = $clog2(MAX_CLASSES + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);

  sce_state_t state_r, state_nxt;

  logic [10:0]        ncls_r;
  logic [CW-1:0]      eff;
  logic [CW-1:0]      cnt_r;
  logic signed [15:0] max_r;
  logic [15:0]        lbl_r;
  logic [RW-1:0]      rows_r;
  logic [47:0]        acc_r;
  logic               err_r;
  logic               last_r;
  logic [CW-1:0]      rcnt_r, rd_idx_r, issued_r, got_r;
  logic [27:0]        sum_r;
  logic [AW-1:0]      raddr;
  logic [15:0]        rdata;
  logic [4:0]         p_r;
  logic [31:0]        x_r;
  logic [4:0]         it_r;
  logic [15:0]        frac_r;
  logic [15:0]        dlab_r;
  logic [1:0]         vpipe_r;
  logic [16:0]        e;
  logic [15:0]        dscan;
  logic [47:0]        q_r, rem_r;
  logic [5:0]         dit_r;
  logic [31:0]        mean_r;
  logic               out_v_r;

  wire in_x  = in_ch.valid & in_ch.ready;
  wire cfg_x = cfg_ch.valid & cfg_ch.ready;

  always_comb begin
    if (ncls_r == 11'd0) eff = CW'(1);
    else if ({21'd0, ncls_r} > MAX_CLASSES) eff = CW'(MAX_CLASSES);
    else eff = CW'(ncls_r);
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  logic [CW-1:0] cnt_inc;
  logic signed [15:0] max_base, max_new;
  assign cnt_inc  = cnt_r + CW'(1);
  assign max_base = (cnt_r == '0) ? 16'sh8000 : max_r;
  assign max_new  = (in_ch.logit > max_base) ? in_ch.logit : max_base;
  wire row_end = in_x & (cnt_inc >= eff);

  // label of the row in progress: taken from the first logit's transfer
  logic [15:0] lbl_cur;
  logic        lbl_bad;
  logic        issue;
  assign lbl_cur = (cnt_r == '0) ? in_ch.label : lbl_r;
  assign lbl_bad = (lbl_cur >= 16'(eff));
  assign issue   = (state_r == ST_SCAN) && (issued_r != rcnt_r);

  sce_store #(.DEPTH(MAX_CLASSES), .AW(AW)) u_store (
    .clk(clk), .we(in_x), .waddr(cnt_r[AW-1:0]), .wdata(in_ch.logit),
    .raddr(raddr), .rdata(rdata)
  );

  assign dscan = 16'(max_r - $signed(rdata));
  sce_exp u_exp (.clk(clk), .d(dscan), .e(e));

  assign raddr = (state_r == ST_SCAN) ? rd_idx_r[AW-1:0] : lbl_r[AW-1:0];

  // log2 mantissa squaring
  logic [63:0] sq;
  assign sq = {32'd0, x_r} * {32'd0, x_r};
  logic [31:0] sqs;
  assign sqs = sq[61:30];

  logic [4:0] msb;
  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 28; i++) if (sum_r[i]) msb = 5'(i);
  end

  logic [20:0] lg;
  logic [38:0] lnp;
  logic [47:0] loss, acc_sum;
  logic [48:0] acc_add;
  assign lg      = {p_r - 5'd16, frac_r};
  assign lnp     = {18'd0, lg} * {22'd0, LN2_Q16} + 39'd32768;
  assign loss    = {25'd0, lnp[38:16]} + {24'd0, dlab_r, 8'd0};
  assign acc_add = {1'b0, acc_r} + {1'b0, loss};
  assign acc_sum = acc_add[48] ? {48{1'b1}} : acc_add[47:0];

  logic [48:0] rsh;
  logic [48:0] dsub;
  assign rsh  = {rem_r, q_r[47]};
  assign dsub = rsh - {{(49-RW){1'b0}}, rows_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (row_end) begin
        if (lbl_bad) state_nxt = in_ch.last_in_batch ? ST_DIV : ST_IDLE;
        else state_nxt = ST_SCAN;
      end else if (in_x && in_ch.last_in_batch) state_nxt = ST_DIV;
      ST_SCAN:      if (issued_r == rcnt_r) state_nxt = ST_SCAN_WAIT;
      ST_SCAN_WAIT: if (got_r == rcnt_r) state_nxt = ST_LBL;
      ST_LBL:       state_nxt = ST_LN_NORM;
      ST_LN_NORM:   state_nxt = ST_LN_SQ;
      ST_LN_SQ:     if (it_r == 5'd16) state_nxt = ST_ACC;
      ST_ACC:       state_nxt = last_r ? ST_DIV : ST_IDLE;
      ST_DIV:       if (dit_r == 6'd48) state_nxt = ST_OUT;
      ST_OUT:       if (out_ch.ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ncls_r  <= 11'd1;
      cnt_r   <= '0;
      max_r   <= 16'sh8000;
      lbl_r   <= '0;
      rows_r  <= '0;
      acc_r   <= '0;
      err_r   <= 1'b0;
      last_r  <= 1'b0;
      vpipe_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_x) ncls_r <= cfg_ch.data;
      vpipe_r <= {vpipe_r[0], issue};
      unique case (state_r)
        ST_IDLE: if (in_x) begin
          last_r <= in_ch.last_in_batch;
          max_r  <= max_new;
          if (cnt_r == '0) lbl_r <= in_ch.label;
          if (row_end) begin
            cnt_r    <= '0;
            rcnt_r   <= cnt_inc;
            rd_idx_r <= '0;
            issued_r <= '0;
            got_r    <= '0;
            sum_r    <= '0;
            if (lbl_bad) err_r <= 1'b1;
          end else if (in_ch.last_in_batch) begin
            cnt_r <= '0;
          end else begin
            cnt_r <= cnt_inc;
          end
          if (in_ch.last_in_batch && (!row_end || lbl_bad)) begin
            q_r <= acc_r; rem_r <= '0; dit_r <= '0;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_idx_r <= rd_idx_r + CW'(1);
            issued_r <= issued_r + CW'(1);
          end
          if (vpipe_r[1]) begin
            sum_r <= sum_r + 28'(e);
            got_r <= got_r + CW'(1);
          end
        end
        ST_SCAN_WAIT: if (vpipe_r[1]) begin
          sum_r <= sum_r + 28'(e);
          got_r <= got_r + CW'(1);
        end
        ST_LBL: ;
        ST_LN_NORM: begin
          dlab_r <= 16'(max_r - $signed(rdata));
          p_r    <= msb;
          x_r    <= 32'({4'd0, sum_r} << (5'd30 - msb));
          it_r   <= '0;
          frac_r <= '0;
        end
        ST_LN_SQ: if (it_r != 5'd16) begin
          it_r <= it_r + 5'd1;
          if (sqs[31]) begin
            x_r <= {1'b0, sqs[31:1]}; frac_r <= {frac_r[14:0], 1'b1};
          end else begin
            x_r <= sqs; frac_r <= {frac_r[14:0], 1'b0};
          end
        end
        ST_ACC: begin
          if ({{(32-RW){1'b0}}, rows_r} < MAX_ROWS) begin
            acc_r  <= acc_sum;
            rows_r <= rows_r + RW'(1);
            q_r    <= acc_sum;
          end else q_r <= acc_r;
          rem_r <= '0; dit_r <= '0;
        end
        ST_DIV: if (dit_r != 6'd48) begin
          dit_r <= dit_r + 6'd1;
          if (!dsub[48]) begin
            rem_r <= dsub[47:0]; q_r <= {q_r[46:0], 1'b1};
          end else begin
            rem_r <= rsh[47:0];  q_r <= {q_r[46:0], 1'b0};
          end
        end
        ST_OUT: if (out_ch.ready) begin
          acc_r <= '0; rows_r <= '0; cnt_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_r == '0) mean_r = '0;
    else if (q_r[47:32] != 16'd0) mean_r = 32'hFFFF_FFFF;
    else mean_r = q_r[31:0];
  end

  assign out_v_r          = (state_r == ST_OUT);
  assign out_ch.valid     = out_v_r;
  assign out_ch.avg_loss  = mean_r;
  assign out_ch.status    = err_r;
  assign out_ch.row_total = 17'(rows_r);
endmodule
